// ----- design/rltm_pkg.sv -----
// ----------------------------------------------------------------------------
// rltm_pkg
// Shared types and constants of the rational luma tone map pipeline.
// ----------------------------------------------------------------------------
package rltm_pkg;

   // Component and luma width, unsigned Q4.12
   localparam int unsigned PIX_W      = 16;
   // Weight register width, unsigned Q8.16
   localparam int unsigned WEIGHT_W   = 24;
   // Fraction bits of the weights and of the scale
   localparam int unsigned FRAC_W     = 16;
   // Luma product width (16 x 16)
   localparam int unsigned LPROD_W    = 2 * PIX_W;
   // Weight times luma (24 x 16)
   localparam int unsigned WPROD_W    = WEIGHT_W + PIX_W;
   // Numerator and denominator, Q13.28, one carry bit above the product
   localparam int unsigned NUMDEN_W   = WPROD_W + 1;
   // Scale quotient, Q13.16; numerator below 2^41 and denominator at least 2^28
   localparam int unsigned QUOT_W     = NUMDEN_W + FRAC_W - 28;
   // Component times scale
   localparam int unsigned CPROD_W    = PIX_W + QUOT_W;

   // BT.2020 luma weights, Q0.16
   localparam logic [PIX_W-1:0] LUMA_WR = 16'd17216;
   localparam logic [PIX_W-1:0] LUMA_WG = 16'd44433;
   localparam logic [PIX_W-1:0] LUMA_WB = 16'd3886;

   // 1.0 in Q4.12 and in Q13.28
   localparam logic [PIX_W-1:0]    ONE_Q12 = 16'd4096;
   localparam logic [NUMDEN_W-1:0] ONE_Q28 = NUMDEN_W'(64'd1 << 28);

   // Register map
   typedef enum logic {
      REG_NUM_WEIGHT = 1'b0,
      REG_DEN_WEIGHT = 1'b1
   } reg_index_type;

   // One pixel as it travels down the pipe
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             last_pixel;
      logic             luma_zero;
   } pixel_type;

endpackage

// ----- design/rltm_divider.sv -----
// ----------------------------------------------------------------------------
// rltm_divider
// Pipelined restoring divider: one quotient bit per stage, forms the Q13.16
// scale (num << 16) / den, with the pixel carried alongside.
// ----------------------------------------------------------------------------
module rltm_divider
   import rltm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUMDEN_W-1:0] in_num,
   input  logic [NUMDEN_W-1:0] in_den,
   input  pixel_type           in_pixel,
   output logic                out_valid,
   output logic [QUOT_W-1:0]   out_quot,
   output pixel_type           out_pixel
);

   typedef struct packed {
      logic [NUMDEN_W-1:0] rem;
      logic [QUOT_W-1:0]   low;
      logic [QUOT_W-1:0]   quot;
      logic [NUMDEN_W-1:0] den;
      pixel_type           pix;
   } div_stage_type;

   logic [NUMDEN_W+FRAC_W-1:0] dividend;
   div_stage_type              head;
   div_stage_type              stage_ff [QUOT_W];
   logic                       valid_ff [QUOT_W];

   // Quotient fits in QUOT_W bits, so the top of the dividend starts below den
   assign dividend  = {in_num, FRAC_W'(0)};
   assign head.rem  = NUMDEN_W'(dividend >> QUOT_W);
   assign head.low  = dividend[QUOT_W-1:0];
   assign head.quot = '0;
   assign head.den  = in_den;
   assign head.pix  = in_pixel;

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      div_stage_type     stage_cur;
      div_stage_type     stage_in;
      logic              valid_cur;
      logic [NUMDEN_W:0] trial;

      if (k == 0) begin : g_head
         assign stage_cur = head;
         assign valid_cur = in_valid;
      end else begin : g_body
         assign stage_cur = stage_ff[k-1];
         assign valid_cur = valid_ff[k-1];
      end

      // Shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial        = {stage_cur.rem, stage_cur.low[QUOT_W-1]};
         stage_in     = stage_cur;
         stage_in.low = stage_cur.low << 1;
         if (trial >= {1'b0, stage_cur.den}) begin
            stage_in.rem  = NUMDEN_W'(trial - {1'b0, stage_cur.den});
            stage_in.quot = {stage_cur.quot[QUOT_W-2:0], 1'b1};
         end else begin
            stage_in.rem  = trial[NUMDEN_W-1:0];
            stage_in.quot = {stage_cur.quot[QUOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k] <= stage_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_cur;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = stage_ff[QUOT_W-1].quot;
   assign out_pixel = stage_ff[QUOT_W-1].pix;

`ifndef SYNTH
   // Every beat passes through one stage per quotient bit and comes out at the end
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##QUOT_W out_valid)
      else $error("divider beat lost");

   // Final remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (stage_ff[QUOT_W-1].rem < stage_ff[QUOT_W-1].den))
      else $error("divider remainder out of range");
`endif

endmodule

// ----- design/rational_luma_tone_map.sv -----
// ----------------------------------------------------------------------------
// rational_luma_tone_map
// Per-pixel tone map: scales linear Q4.12 RGB by (1 + A*L) / (1 + B*L).
// ----------------------------------------------------------------------------
// The block takes one pixel in every cycle (busy is always low) and returns
// each pixel with rsp_strobe high for one cycle; the receiver must take
// every beat as it comes. The pipeline is the 29-stage restoring divider
// that forms the Q13.16 scale, with four stages before it for luma and
// numerator/denominator and two after it for the final products and clamp.
// Weights are written over the APB port at byte addresses 0 (A) and 4 (B)
// and must only change while no pixel is in flight.
module rational_luma_tone_map
   import rltm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Input channel
   input  logic             start,
   output logic             busy,
   input  logic [PIX_W-1:0] req_red_in,
   input  logic [PIX_W-1:0] req_green_in,
   input  logic [PIX_W-1:0] req_blue_in,
   input  logic             req_last_pixel_in,
   // Result channel
   output logic             rsp_strobe,
   output logic [PIX_W-1:0] rsp_red_out,
   output logic [PIX_W-1:0] rsp_green_out,
   output logic [PIX_W-1:0] rsp_blue_out,
   output logic             rsp_last_pixel_out,
   // Configuration port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int unsigned LATENCY = 4 + QUOT_W + 2;

   logic [WEIGHT_W-1:0] num_weight_ff;
   logic [WEIGHT_W-1:0] den_weight_ff;
   reg_index_type       reg_index;
   logic                csr_write;

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   pixel_type           s1_pix_ff, s2_pix_ff, s3_pix_ff, s4_pix_ff, s5_pix_ff;
   logic [LPROD_W-1:0]  prod_r_ff, prod_g_ff, prod_b_ff;
   logic [LPROD_W+1:0]  luma_sum;
   logic [PIX_W-1:0]    luma_ff;
   logic [WPROD_W-1:0]  an_ff, bn_ff;
   logic [NUMDEN_W-1:0] num_ff, den_ff;

   logic                div_valid;
   logic [QUOT_W-1:0]   div_quot;
   pixel_type           div_pixel;

   logic [CPROD_W-1:0]  cprod_r_ff, cprod_g_ff, cprod_b_ff;

   logic                out_valid_ff;
   logic                out_zero_ff;
   logic                out_last_ff;
   logic [PIX_W-1:0]    out_red_ff, out_green_ff, out_blue_ff;

   // Clamp a scaled component to 1.0
   function automatic logic [PIX_W-1:0] clamp_q12(input logic [CPROD_W-1:0] prod);
      logic [CPROD_W-FRAC_W-1:0] p;
      p = prod[CPROD_W-1:FRAC_W];
      if (p > (CPROD_W-FRAC_W)'(ONE_Q12)) begin
         return ONE_Q12;
      end
      return p[PIX_W-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign reg_index = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_weight_ff <= '0;
         den_weight_ff <= '0;
      end else if (csr_write) begin
         case (reg_index)
            REG_NUM_WEIGHT: num_weight_ff <= pwdata[WEIGHT_W-1:0];
            REG_DEN_WEIGHT: den_weight_ff <= pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_NUM_WEIGHT: prdata = 32'(num_weight_ff);
         REG_DEN_WEIGHT: prdata = 32'(den_weight_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- valid chain ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= div_valid;
         out_valid_ff <= s5_valid_ff;
      end
   end

   // Stage 1: luma weight products
   always_ff @(posedge clock) begin
      prod_r_ff            <= LPROD_W'(req_red_in) * LPROD_W'(LUMA_WR);
      prod_g_ff            <= LPROD_W'(req_green_in) * LPROD_W'(LUMA_WG);
      prod_b_ff            <= LPROD_W'(req_blue_in) * LPROD_W'(LUMA_WB);
      s1_pix_ff.red        <= req_red_in;
      s1_pix_ff.green      <= req_green_in;
      s1_pix_ff.blue       <= req_blue_in;
      s1_pix_ff.last_pixel <= req_last_pixel_in;
      s1_pix_ff.luma_zero  <= 1'b0;
   end

   // Stage 2: luma, truncated to Q4.12
   assign luma_sum = (LPROD_W+2)'(prod_r_ff) + (LPROD_W+2)'(prod_g_ff)
                   + (LPROD_W+2)'(prod_b_ff);

   always_ff @(posedge clock) begin
      luma_ff   <= luma_sum[LPROD_W-1:FRAC_W];
      s2_pix_ff <= s1_pix_ff;
   end

   // Stage 3: weight times luma
   always_ff @(posedge clock) begin
      an_ff                <= WPROD_W'(num_weight_ff) * WPROD_W'(luma_ff);
      bn_ff                <= WPROD_W'(den_weight_ff) * WPROD_W'(luma_ff);
      s3_pix_ff.red        <= s2_pix_ff.red;
      s3_pix_ff.green      <= s2_pix_ff.green;
      s3_pix_ff.blue       <= s2_pix_ff.blue;
      s3_pix_ff.last_pixel <= s2_pix_ff.last_pixel;
      s3_pix_ff.luma_zero  <= (luma_ff == '0);
   end

   // Stage 4: add 1.0 to numerator and denominator
   always_ff @(posedge clock) begin
      num_ff    <= ONE_Q28 + NUMDEN_W'(an_ff);
      den_ff    <= ONE_Q28 + NUMDEN_W'(bn_ff);
      s4_pix_ff <= s3_pix_ff;
   end

   // Scale quotient
   rltm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_pixel  (s4_pix_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_pixel (div_pixel)
   );

   // Stage 5: component times scale
   always_ff @(posedge clock) begin
      cprod_r_ff <= CPROD_W'(div_pixel.red) * CPROD_W'(div_quot);
      cprod_g_ff <= CPROD_W'(div_pixel.green) * CPROD_W'(div_quot);
      cprod_b_ff <= CPROD_W'(div_pixel.blue) * CPROD_W'(div_quot);
      s5_pix_ff  <= div_pixel;
   end

   // Stage 6: clamp, or pass through on zero luma
   always_ff @(posedge clock) begin
      out_zero_ff <= s5_pix_ff.luma_zero;
      out_last_ff <= s5_pix_ff.last_pixel;
      if (s5_pix_ff.luma_zero) begin
         out_red_ff   <= s5_pix_ff.red;
         out_green_ff <= s5_pix_ff.green;
         out_blue_ff  <= s5_pix_ff.blue;
      end else begin
         out_red_ff   <= clamp_q12(cprod_r_ff);
         out_green_ff <= clamp_q12(cprod_g_ff);
         out_blue_ff  <= clamp_q12(cprod_b_ff);
      end
   end

   assign rsp_strobe         = out_valid_ff;
   assign rsp_red_out        = out_red_ff;
   assign rsp_green_out      = out_green_ff;
   assign rsp_blue_out       = out_blue_ff;
   assign rsp_last_pixel_out = out_last_ff;

`ifndef SYNTH
   // Every accepted beat comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("pixel beat lost in pipeline");

   // Mapped components never exceed 1.0
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !out_zero_ff) |-> ((rsp_red_out <= ONE_Q12)
         && (rsp_green_out <= ONE_Q12) && (rsp_blue_out <= ONE_Q12)))
      else $error("mapped component above 1.0");

   // Input side never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("input stalled");
`endif

endmodule

// ----- dv/tb_rational_luma_tone_map.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_luma_tone_map
// Self-checking bench for the rational luma tone map. A scoreboard class
// predicts each mapped pixel from the accepted input beat and the current
// weights, and compares every result beat field by field in order. Stimulus
// runs a short directed set over extreme weights and pixels, then random
// segments under changing weights and sender idle rates. Weights are
// programmed over APB only while no pixel is in flight, and read back.
// ----------------------------------------------------------------------------
module tb_rational_luma_tone_map;
   import rltm_pkg::*;

   localparam logic [2:0] ADDR_NUM_WEIGHT = {REG_NUM_WEIGHT, 2'b00};
   localparam logic [2:0] ADDR_DEN_WEIGHT = {REG_DEN_WEIGHT, 2'b00};
   localparam int unsigned STALL_LIMIT    = 2000;
   localparam int unsigned PIPE_LATENCY   = 35;
   localparam int unsigned SEGMENTS       = 6;
   localparam int unsigned SEGMENT_BEATS  = 108;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             last;
   } tone_pixel_type;

   // Predicts mapped pixels and holds them until the block returns them
   class tone_map_checker;
      logic [WEIGHT_W-1:0] num_weight;
      logic [WEIGHT_W-1:0] den_weight;
      tone_pixel_type      expected_pixels[$];
      int unsigned         mismatches;
      int unsigned         checked;

      function new();
         num_weight = '0;
         den_weight = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // Component times Q13.16 scale, truncated, clamped to 1.0
      function logic [PIX_W-1:0] scale_component(logic [PIX_W-1:0] c, logic [63:0] scale);
         logic [63:0] prod;
         prod = ({48'd0, c} * scale) >> FRAC_W;
         return (prod > 64'(ONE_Q12)) ? ONE_Q12 : prod[PIX_W-1:0];
      endfunction

      function tone_pixel_type map_pixel(tone_pixel_type px);
         logic [63:0] luma;
         logic [63:0] num;
         logic [63:0] den;
         logic [63:0] scale;
         tone_pixel_type res;
         luma = (64'(LUMA_WR) * 64'(px.red) + 64'(LUMA_WG) * 64'(px.green)
                 + 64'(LUMA_WB) * 64'(px.blue)) >> FRAC_W;
         res.last = px.last;
         if (luma == 0) begin
            // zero luma: pass through, no clamp
            res.red   = px.red;
            res.green = px.green;
            res.blue  = px.blue;
         end else begin
            num       = (64'd1 << 28) + 64'(num_weight) * luma;
            den       = (64'd1 << 28) + 64'(den_weight) * luma;
            scale     = (num << FRAC_W) / den;
            res.red   = scale_component(px.red, scale);
            res.green = scale_component(px.green, scale);
            res.blue  = scale_component(px.blue, scale);
         end
         return res;
      endfunction

      function void note_pixel(tone_pixel_type px);
         expected_pixels.push_back(map_pixel(px));
      endfunction

      function void set_weight(logic [2:0] addr, logic [31:0] data);
         if (addr == ADDR_NUM_WEIGHT) num_weight = data[WEIGHT_W-1:0];
         else if (addr == ADDR_DEN_WEIGHT) den_weight = data[WEIGHT_W-1:0];
      endfunction

      function void check_readback(logic [2:0] addr, logic [31:0] data);
         logic [31:0] want;
         if (addr == ADDR_NUM_WEIGHT) want = {8'd0, num_weight};
         else if (addr == ADDR_DEN_WEIGHT) want = {8'd0, den_weight};
         else return;
         if (data !== want)
            flag($sformatf("weight readback addr %0d: expected %h got %h", addr, want, data));
      endfunction

      function void check_pixel(tone_pixel_type got);
         tone_pixel_type want;
         if (expected_pixels.size() == 0) begin
            flag($sformatf("result beat with no pixel in flight: r=%h g=%h b=%h last=%b",
                           got.red, got.green, got.blue, got.last));
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.last !== want.last)
            flag($sformatf({"pixel %0d: expected r=%h g=%h b=%h last=%b, ",
                            "got r=%h g=%h b=%h last=%b"},
                           checked, want.red, want.green, want.blue, want.last,
                           got.red, got.green, got.blue, got.last));
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [PIX_W-1:0] req_red_in;
   logic [PIX_W-1:0] req_green_in;
   logic [PIX_W-1:0] req_blue_in;
   logic             req_last_pixel_in;
   logic             rsp_strobe;
   logic [PIX_W-1:0] rsp_red_out;
   logic [PIX_W-1:0] rsp_green_out;
   logic [PIX_W-1:0] rsp_blue_out;
   logic             rsp_last_pixel_out;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [2:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;

   tone_map_checker  sb;
   int unsigned      stall_cycles;
   int unsigned      idle_pct;
   int unsigned      settings;

   rational_luma_tone_map u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_red_in         (req_red_in),
      .req_green_in       (req_green_in),
      .req_blue_in        (req_blue_in),
      .req_last_pixel_in  (req_last_pixel_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_red_out        (rsp_red_out),
      .rsp_green_out      (rsp_green_out),
      .rsp_blue_out       (rsp_blue_out),
      .rsp_last_pixel_out (rsp_last_pixel_out),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: input beats, result beats and APB accesses, all sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_pixel('{req_red_in, req_green_in, req_blue_in, req_last_pixel_in});
         if (rsp_strobe)
            sb.check_pixel('{rsp_red_out, rsp_green_out, rsp_blue_out, rsp_last_pixel_out});
         if (psel && penable && pready) begin
            if (pwrite) sb.set_weight(paddr, pwdata);
            else sb.check_readback(paddr, prdata);
         end
      end
   end

   // Watchdog: cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one pixel and hold it until taken
   task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic last);
      start             <= 1'b1;
      req_red_in        <= r;
      req_green_in      <= g;
      req_blue_in       <= b;
      req_last_pixel_in <= last;
      do @(posedge clock); while (busy);
   endtask

   // One cycle with no pixel offered; data lines carry junk
   task automatic idle_beat();
      start             <= 1'b0;
      req_red_in        <= PIX_W'($urandom);
      req_green_in      <= PIX_W'($urandom);
      req_blue_in       <= PIX_W'($urandom);
      req_last_pixel_in <= 1'($urandom);
      @(posedge clock);
   endtask

   // Stop offering and wait until every pixel in flight has come back
   task automatic drain_pipe();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Program both weights (upper byte junk, block keeps 24 bits), then read back
   task automatic program_weights(input logic [WEIGHT_W-1:0] a, input logic [WEIGHT_W-1:0] b);
      csr_access(1'b1, ADDR_NUM_WEIGHT, {8'($urandom), a});
      csr_access(1'b1, ADDR_DEN_WEIGHT, {8'($urandom), b});
      csr_access(1'b0, ADDR_NUM_WEIGHT, 32'd0);
      csr_access(1'b0, ADDR_DEN_WEIGHT, 32'd0);
      settings++;
   endtask

   function automatic logic [WEIGHT_W-1:0] rand_weight();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         2:       return WEIGHT_W'($urandom);
         default: return WEIGHT_W'($urandom_range(24'h040000));
      endcase
   endfunction

   // Mix of full range, normal range near 1.0, luma-zero sizes and extremes
   function automatic logic [PIX_W-1:0] rand_component();
      case ($urandom_range(7))
         0, 1, 2: return PIX_W'($urandom);
         3, 4:    return PIX_W'($urandom_range(8191));
         5:       return PIX_W'($urandom_range(3));
         6:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return PIX_W'($urandom_range(4100, 4090));
      endcase
   endfunction

   initial begin
      sb                = new();
      reset             = 1'b1;
      start             = 1'b0;
      req_red_in        = '0;
      req_green_in      = '0;
      req_blue_in       = '0;
      req_last_pixel_in = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      settings          = 0;
      idle_pct          = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset weights: scale 1.0, clamp and luma-zero pass-through
      push_pixel(16'd0, 16'd0, 16'd0, 1'b0);
      push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      push_pixel(16'd1, 16'd0, 16'd0, 1'b0);
      push_pixel(16'd0, 16'd1, 16'd0, 1'b1);
      push_pixel(16'd4096, 16'd4096, 16'd4096, 1'b0);
      drain_pipe();

      // Largest numerator weight: large scales
      program_weights('1, '0);
      push_pixel(16'd0, 16'd0, 16'd0, 1'b1);
      push_pixel(16'd1, 16'd1, 16'd1, 1'b0);
      push_pixel(16'd0, 16'd2, 16'd0, 1'b0);
      push_pixel(16'hFFFF, 16'd0, 16'd0, 1'b1);
      push_pixel(16'd0, 16'hFFFF, 16'd0, 1'b0);
      push_pixel(16'd0, 16'd0, 16'hFFFF, 1'b1);
      push_pixel(16'd100, 16'd200, 16'd50, 1'b0);
      drain_pipe();

      // Largest denominator weight: strong compression
      program_weights('0, '1);
      push_pixel(16'd0, 16'd2, 16'd0, 1'b1);
      push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      push_pixel(16'd4096, 16'd8192, 16'd2048, 1'b1);
      push_pixel(16'hFFFF, 16'd0, 16'd0, 1'b0);
      push_pixel(16'd0, 16'd0, 16'd1, 1'b1);
      drain_pipe();

      // Both weights at maximum: scale exactly 1.0
      program_weights('1, '1);
      push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      push_pixel(16'd3000, 16'd4000, 16'd5000, 1'b0);
      push_pixel(16'd0, 16'd0, 16'd5, 1'b0);

      // Random segments: new weights each, sender idle 14%, then 61%, then none
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_pipe();
         if (seg == 0) program_weights(WEIGHT_W'($urandom_range(24'h020000)),
                                       WEIGHT_W'($urandom_range(24'h020000)));
         else program_weights(rand_weight(), rand_weight());
         idle_pct = (seg < 2) ? 14 : (seg < 4) ? 61 : 0;
         for (int n = 0; n < SEGMENT_BEATS; n++) begin
            push_pixel(rand_component(), rand_component(), rand_component(),
                       ($urandom_range(7) == 0));
            while ($urandom_range(99) < idle_pct) idle_beat();
         end
      end

      drain_pipe();
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (sb.pending() != 0)
         sb.flag($sformatf("%0d pixels never returned", sb.pending()));

      $display("Checked %0d mapped pixels under %0d weight settings,", sb.checked, settings);
      $display("with extreme weights, luma-zero pixels and idle and back-to-back input.");
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/rltm_pkg.sv
design/rltm_divider.sv
design/rational_luma_tone_map.sv
dv/tb_rational_luma_tone_map.sv
